[rtl/core/light_to_servo_smoothing_unit_macros.svh]
// ----------------------------------------------------------------------------
// Light to servo smoothing unit: assertion macros
// Checks that the RTL writes on a single line each. They expand to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef LIGHT_TO_SERVO_SMOOTHING_UNIT_MACROS_SVH
`define LIGHT_TO_SERVO_SMOOTHING_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LSS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define LSS_ASSERT_SAME(label, ante, cons)
`define LSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/lss_pkg.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing: shared package
// Field widths, register indexes, reset values, sequencer states and the
// control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int SAMPLE_W  = 10;
	localparam int ELAPSED_W = 8;
	localparam int ANGLE_W   = 8;
	localparam int GAIN_W    = 9;
	localparam int DEAD_W    = 8;
	localparam int IDLE_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_W     = 18;

	localparam logic [GAIN_W-1:0]   GAIN_ONE     = 9'd256;
	localparam logic [GAIN_W-1:0]   ANGLE_SPAN   = 9'd180;
	localparam logic [GAIN_W-1:0]   LEVEL_SPAN   = 9'd200;
	localparam logic [DIV_W-1:0]    DIVISOR      = 18'd1023;
	localparam logic [ANGLE_W-1:0]  TGT_OFFSET   = 8'd10;
	localparam logic [ANGLE_W-1:0]  TGT_RAW_HI   = 8'd190;
	localparam logic [ANGLE_W-1:0]  ANGLE_MAX    = 8'd180;
	localparam logic [ANGLE_W-1:0]  ANGLE_RST    = 8'd90;

	localparam logic [GAIN_W-1:0]   SMOOTH_RST   = 9'd13;
	localparam logic [GAIN_W-1:0]   SLEW_RST     = 9'd26;
	localparam logic [DEAD_W-1:0]   DEAD_RST     = 8'd2;
	localparam logic [IDLE_W-1:0]   TIMEOUT_RST  = 16'd1000;
	localparam logic [SAMPLE_W-1:0] DARK_RST     = 10'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SMOOTHING_GAIN   = 3'd0,
		CFG_SLEW_GAIN        = 3'd1,
		CFG_DEADBAND_DEGREES = 3'd2,
		CFG_IDLE_LIMIT       = 3'd3,
		CFG_DARK_THRESHOLD   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRI_MUL,
		ST_PRI_EST,
		ST_PRI_FIX,
		ST_EMA_NEW,
		ST_EMA_OLD,
		ST_LVL_MUL,
		ST_TGT_EST,
		ST_TGT_FIX,
		ST_SLEW_MUL,
		ST_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		OPA_SAMPLE_FRAC,
		OPA_AVG,
		OPA_SAMPLE,
		OPA_LEVEL,
		OPA_GAP
	} opa_sel_t;

	typedef enum logic [2:0] {
		OPB_GAIN,
		OPB_GAIN_REST,
		OPB_ANGLE_SPAN,
		OPB_LEVEL_SPAN,
		OPB_SLEW
	} opb_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     mul_en;
		logic     mul_acc;
		opa_sel_t a_sel;
		opb_sel_t b_sel;
		logic     est_en;
		logic     ang_fix;
		logic     lvl_load;
		logic     tgt_fix;
		logic     slew_en;
		logic     commit;
	} ctrl_t;

endpackage

[rtl/core/lss_if.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing: stream interfaces
// Valid/ready channels for the sample items and the result items.
// ----------------------------------------------------------------------------
interface lss_sample_if;
	import lss_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SAMPLE_W-1:0]  light_sample;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, light_sample, elapsed_ms, input ready);
	modport sink (input valid, light_sample, elapsed_ms, output ready);
endinterface

interface lss_result_if;
	import lss_pkg::*;

	logic                valid;
	logic                ready;
	logic [ANGLE_W-1:0]  servo_angle;
	logic [ANGLE_W-1:0]  target_angle;
	logic                servo_enabled;
	logic                moved;
	logic [SAMPLE_W-1:0] light_level;
	logic                is_dark;

	modport source (output valid, servo_angle, target_angle, servo_enabled, moved,
		light_level, is_dark, input ready);
	modport sink (input valid, servo_angle, target_angle, servo_enabled, moved,
		light_level, is_dark, output ready);
endinterface

[rtl/core/lss_mac.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing: shared multiply-accumulate unit
// One multiplier with a registered product that can either restart or add
// to the previous result.
// ----------------------------------------------------------------------------
module lss_mac #(
	parameter int A_W = 18
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic                                   acc,
	input  logic [A_W-1:0]                         a,
	input  logic [lss_pkg::GAIN_W-1:0]             b,
	output logic [A_W+lss_pkg::GAIN_W-1:0]         p_q
);
	import lss_pkg::*;

	localparam int P_W = A_W + GAIN_W;

	logic [P_W-1:0] prod;
	logic [P_W-1:0] base;

	assign prod = a * b;
	assign base = acc ? p_q : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= base + prod;
		end
	end
endmodule

[rtl/core/lss_div1023.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing: divide by 1023
// An estimate from a reciprocal by shift and add is registered first; the
// quotient then follows from one remainder compare.
// ----------------------------------------------------------------------------
module lss_div1023 (
	input  logic                         clk,
	input  logic                         est_en,
	input  logic [lss_pkg::DIV_W-1:0]    dividend,
	output logic [lss_pkg::ANGLE_W-1:0]  quotient
);
	import lss_pkg::*;

	logic [DIV_W+9:0]   scaled;
	logic [ANGLE_W-1:0] est_q;
	logic [DIV_W-1:0]   back;
	logic [DIV_W-1:0]   rem;

	// 1025 / 2^20 sits just below 1/1023, so the estimate is short by at most one.
	assign scaled = {dividend, 10'b0} + (DIV_W+10)'(dividend);

	always_ff @(posedge clk) begin
		if (est_en) begin
			est_q <= scaled[DIV_W+9:20];
		end
	end

	assign back     = {est_q, 10'b0} - DIV_W'(est_q);
	assign rem      = dividend - back;
	assign quotient = (rem >= DIVISOR) ? est_q + 8'd1 : est_q;
endmodule

[rtl/core/lss_seq.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing: sequencer
// Steps one item through the shared multiplier and divider and hands the
// datapath its control bundle.
// ----------------------------------------------------------------------------
module lss_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           primed,
	input  logic           commit_ok,
	output lss_pkg::ctrl_t ctrl
);
	import lss_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = primed ? ST_EMA_NEW : ST_PRI_MUL;
				end
			end
			ST_PRI_MUL:  state_d = ST_PRI_EST;
			ST_PRI_EST:  state_d = ST_PRI_FIX;
			ST_PRI_FIX:  state_d = ST_LVL_MUL;
			ST_EMA_NEW:  state_d = ST_EMA_OLD;
			ST_EMA_OLD:  state_d = ST_LVL_MUL;
			ST_LVL_MUL:  state_d = ST_TGT_EST;
			ST_TGT_EST:  state_d = ST_TGT_FIX;
			ST_TGT_FIX:  state_d = primed ? ST_SLEW_MUL : ST_COMMIT;
			ST_SLEW_MUL: state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (commit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl       = '0;
		ctrl.a_sel = OPA_SAMPLE;
		ctrl.b_sel = OPB_GAIN;
		unique case (state_q)
			ST_IDLE:     ctrl.in_ready = 1'b1;
			ST_PRI_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.a_sel  = OPA_SAMPLE;
				ctrl.b_sel  = OPB_ANGLE_SPAN;
			end
			ST_PRI_EST:  ctrl.est_en = 1'b1;
			ST_PRI_FIX:  ctrl.ang_fix = 1'b1;
			ST_EMA_NEW: begin
				ctrl.mul_en = 1'b1;
				ctrl.a_sel  = OPA_SAMPLE_FRAC;
				ctrl.b_sel  = OPB_GAIN;
			end
			ST_EMA_OLD: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_acc = 1'b1;
				ctrl.a_sel   = OPA_AVG;
				ctrl.b_sel   = OPB_GAIN_REST;
			end
			ST_LVL_MUL: begin
				ctrl.mul_en   = 1'b1;
				ctrl.lvl_load = 1'b1;
				ctrl.a_sel    = OPA_LEVEL;
				ctrl.b_sel    = OPB_LEVEL_SPAN;
			end
			ST_TGT_EST:  ctrl.est_en = 1'b1;
			ST_TGT_FIX:  ctrl.tgt_fix = 1'b1;
			ST_SLEW_MUL: begin
				ctrl.mul_en  = 1'b1;
				ctrl.slew_en = 1'b1;
				ctrl.a_sel   = OPA_GAP;
				ctrl.b_sel   = OPB_SLEW;
			end
			ST_COMMIT:   ctrl.commit = commit_ok;
			default:     ctrl = '0;
		endcase
	end
endmodule

[rtl/core/light_to_servo_smoothing_unit.sv]
// ----------------------------------------------------------------------------
// Light to servo smoothing unit: top level
// Smooths a light sensor level and slews a servo angle towards the target
// derived from it, with a deadband and an idle detach timeout.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result transfer. The block handles
// one item at a time: it takes the sample in the cycle its ready is high and
// is ready again when the item is done, provided the result register was free
// when the item finished; otherwise it waits in its final step until the
// previous result has been taken. The steps are set by the single shared
// multiply-accumulate unit, used four times per normal item (new-sample term,
// old-average term, level scaling and slew step) and twice for the first item
// (angle scaling and level scaling), and by the divide-by-1023 unit, which
// registers an estimate, then corrects it. The first item after reset primes
// the filter: the level becomes the sample, the angle becomes the sample
// mapped to 0..180 and the servo stays detached. Configuration writes are
// taken on any cycle with cfg_we high and must only be made while the block
// is idle. The level is held with FRAC_BITS fractional bits, as is the angle.
// ----------------------------------------------------------------------------
`include "light_to_servo_smoothing_unit_macros.svh"

module light_to_servo_smoothing_unit #(
	parameter int FRAC_BITS = lss_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lss_pkg::CFG_W-1:0]      cfg_data,
	lss_sample_if.sink                     sample_ch,
	lss_result_if.source                   result_ch
);
	import lss_pkg::*;

	// Level is Q10.F, angle is Q8.F, multiplier result carries the gain bits.
	localparam int LW = SAMPLE_W + FRAC_BITS;
	localparam int AW = ANGLE_W + FRAC_BITS;
	localparam int PW = LW + GAIN_W;

	// Configuration registers.
	logic [GAIN_W-1:0]   smooth_gain_q;
	logic [GAIN_W-1:0]   slew_gain_q;
	logic [DEAD_W-1:0]   deadband_q;
	logic [IDLE_W-1:0]   timeout_q;
	logic [SAMPLE_W-1:0] dark_thr_q;

	// Filter and servo state.
	logic [LW-1:0]       avg_q;
	logic [AW-1:0]       angle_q;
	logic [IDLE_W-1:0]   idle_q;
	logic                drive_q;
	logic                primed_q;

	// Per-item working registers.
	logic [SAMPLE_W-1:0]  sample_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [LW-1:0]        avg_new_q;
	logic [ANGLE_W-1:0]   ang_prime_q;
	logic [ANGLE_W-1:0]   tgt_q;
	logic                 up_q;
	logic                 move_q;

	// Result register.
	logic                 out_vld_q;
	logic [ANGLE_W-1:0]   out_angle_q;
	logic [ANGLE_W-1:0]   out_tgt_q;
	logic                 out_enabled_q;
	logic                 out_moved_q;
	logic [SAMPLE_W-1:0]  out_level_q;
	logic                 out_dark_q;

	ctrl_t                ctrl;
	logic                 commit_ok;
	logic                 in_xfer;

	logic [GAIN_W-1:0]    g_smooth;
	logic [GAIN_W-1:0]    g_slew;
	logic [LW-1:0]        op_a;
	logic [GAIN_W-1:0]    op_b;
	logic [PW-1:0]        p_q;
	logic [SAMPLE_W-1:0]  level_int;
	logic [ANGLE_W-1:0]   quotient;
	logic [ANGLE_W-1:0]   tgt_clamped;

	logic [AW-1:0]        tgt_frac;
	logic                 up;
	logic [AW-1:0]        gap;
	logic                 move;
	logic [AW-1:0]        step;

	logic [IDLE_W:0]      idle_sum;
	logic [IDLE_W-1:0]    idle_sat;
	logic [AW-1:0]        angle_d;
	logic [IDLE_W-1:0]    idle_d;
	logic                 drive_d;
	logic                 moved_d;

	// ---------------------------------------------------------------- control
	assign in_xfer         = sample_ch.valid && ctrl.in_ready;
	assign sample_ch.ready = ctrl.in_ready;

	// The final step may only retire when the result register is empty or is
	// being emptied by a transfer in the same cycle.
	assign commit_ok = !out_vld_q || result_ch.ready;

	lss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.primed    (primed_q),
		.commit_ok (commit_ok),
		.ctrl      (ctrl)
	);

	// ---------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_gain_q <= SMOOTH_RST;
			slew_gain_q   <= SLEW_RST;
			deadband_q    <= DEAD_RST;
			timeout_q     <= TIMEOUT_RST;
			dark_thr_q    <= DARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SMOOTHING_GAIN:   smooth_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_SLEW_GAIN:        slew_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_DEADBAND_DEGREES: deadband_q    <= cfg_data[DEAD_W-1:0];
				CFG_IDLE_LIMIT:       timeout_q     <= cfg_data[IDLE_W-1:0];
				CFG_DARK_THRESHOLD:   dark_thr_q    <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Gains above one are treated as exactly one.
	assign g_smooth = (smooth_gain_q > GAIN_ONE) ? GAIN_ONE : smooth_gain_q;
	assign g_slew   = (slew_gain_q > GAIN_ONE) ? GAIN_ONE : slew_gain_q;

	// ------------------------------------------------------ shared arithmetic
	// Integer part of the smoothed level: the fresh filter result on a normal
	// item, the raw sample on the priming item.
	assign level_int = primed_q ? p_q[LW+7:FRAC_BITS+8] : sample_q;

	// Distance from the current angle to the target, with its direction.
	assign tgt_frac = {tgt_q, {FRAC_BITS{1'b0}}};
	assign up       = tgt_frac >= angle_q;
	assign gap      = up ? tgt_frac - angle_q : angle_q - tgt_frac;
	assign move     = gap > {deadband_q, {FRAC_BITS{1'b0}}};

	always_comb begin
		unique case (ctrl.a_sel)
			OPA_SAMPLE_FRAC: op_a = {sample_q, {FRAC_BITS{1'b0}}};
			OPA_AVG:         op_a = avg_q;
			OPA_SAMPLE:      op_a = LW'(sample_q);
			OPA_LEVEL:       op_a = LW'(level_int);
			OPA_GAP:         op_a = LW'(gap);
			default:         op_a = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.b_sel)
			OPB_GAIN:       op_b = g_smooth;
			OPB_GAIN_REST:  op_b = GAIN_ONE - g_smooth;
			OPB_ANGLE_SPAN: op_b = ANGLE_SPAN;
			OPB_LEVEL_SPAN: op_b = LEVEL_SPAN;
			OPB_SLEW:       op_b = g_slew;
			default:        op_b = '0;
		endcase
	end

	lss_mac #(
		.A_W (LW)
	) u_mac (
		.clk (clk),
		.en  (ctrl.mul_en),
		.acc (ctrl.mul_acc),
		.a   (op_a),
		.b   (op_b),
		.p_q (p_q)
	);

	// Scaled products fed to the divider never exceed 1023 * 200.
	lss_div1023 u_div (
		.clk      (clk),
		.est_en   (ctrl.est_en),
		.dividend (p_q[DIV_W-1:0]),
		.quotient (quotient)
	);

	// Target is the scaled level less ten degrees, held within 0..180.
	always_comb begin
		if (quotient < TGT_OFFSET) begin
			tgt_clamped = '0;
		end else if (quotient > TGT_RAW_HI) begin
			tgt_clamped = ANGLE_MAX;
		end else begin
			tgt_clamped = quotient - TGT_OFFSET;
		end
	end

	// ------------------------------------------------------- work registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q  <= sample_ch.light_sample;
			elapsed_q <= sample_ch.elapsed_ms;
		end
		if (ctrl.ang_fix) begin
			ang_prime_q <= quotient;
		end
		if (ctrl.lvl_load) begin
			avg_new_q <= primed_q ? p_q[LW+7:8] : {sample_q, {FRAC_BITS{1'b0}}};
		end
		if (ctrl.tgt_fix) begin
			tgt_q <= tgt_clamped;
		end
		if (ctrl.slew_en) begin
			up_q   <= up;
			move_q <= move;
		end
	end

	// ------------------------------------------------------ state update
	// The step is the gap scaled by the slew gain, truncated towards zero.
	assign step     = p_q[AW+7:8];
	assign idle_sum = {1'b0, idle_q} + (IDLE_W+1)'(elapsed_q);
	assign idle_sat = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];

	always_comb begin
		angle_d = angle_q;
		idle_d  = idle_q;
		drive_d = drive_q;
		moved_d = 1'b0;
		if (!primed_q) begin
			// Priming item: angle jumps to the mapped sample, servo untouched.
			angle_d = {ang_prime_q, {FRAC_BITS{1'b0}}};
		end else if (move_q) begin
			// Outside the deadband: attach and slew, even if the step is zero.
			angle_d = up_q ? angle_q + step : angle_q - step;
			idle_d  = '0;
			drive_d = 1'b1;
			moved_d = 1'b1;
		end else begin
			// Inside the deadband: count idle time and detach after the timeout.
			idle_d  = idle_sat;
			drive_d = drive_q && !(idle_sat > timeout_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q    <= '0;
			angle_q  <= {ANGLE_RST, {FRAC_BITS{1'b0}}};
			idle_q   <= '0;
			drive_q  <= 1'b0;
			primed_q <= 1'b0;
		end else if (ctrl.commit) begin
			avg_q    <= avg_new_q;
			angle_q  <= angle_d;
			idle_q   <= idle_d;
			drive_q  <= drive_d;
			primed_q <= 1'b1;
		end
	end

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_vld_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_angle_q   <= angle_d[AW-1:FRAC_BITS];
			out_tgt_q     <= tgt_q;
			out_enabled_q <= drive_d;
			out_moved_q   <= moved_d;
			out_level_q   <= avg_new_q[LW-1:FRAC_BITS];
			out_dark_q    <= avg_new_q < {dark_thr_q, {FRAC_BITS{1'b0}}};
		end
	end

	assign result_ch.valid         = out_vld_q;
	assign result_ch.servo_angle   = out_angle_q;
	assign result_ch.target_angle  = out_tgt_q;
	assign result_ch.servo_enabled = out_enabled_q;
	assign result_ch.moved         = out_moved_q;
	assign result_ch.light_level   = out_level_q;
	assign result_ch.is_dark       = out_dark_q;

	// ------------------------------------------------------------ assertions
	// Once a sample is taken the block works on it and takes no other.
	`LSS_ASSERT_NEXT(a_busy_after_take, in_xfer, !sample_ch.ready)
	// A moving step always leaves the servo attached.
	`LSS_ASSERT_SAME(a_moved_attached, out_vld_q && out_moved_q, out_enabled_q)
	// Angles stay within the servo travel.
	`LSS_ASSERT_SAME(a_angle_range, out_vld_q, (out_angle_q <= ANGLE_MAX) && (out_tgt_q <= ANGLE_MAX))
	// Priming happens once per reset.
	`LSS_ASSERT_NEXT(a_primed_sticky, primed_q, primed_q)
endmodule

[tb/lss_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light to servo smoothing: result scoreboard
// Mirrors the smoothing filter, target mapping and servo slew of the unit,
// queues the result expected for each sample and compares returned results.
// ----------------------------------------------------------------------------
package lss_scoreboard_pkg;
	import lss_pkg::*;

	localparam int          FRAC         = FRAC_BITS_DEF;
	localparam int          MAX_REPORTED = 10;
	localparam int          LVL_W        = SAMPLE_W + FRAC;
	localparam int          ANG_W        = ANGLE_W + FRAC;
	localparam int unsigned ONE_U        = 32'(GAIN_ONE);
	localparam int unsigned ANGLE_SPAN_U = 32'(ANGLE_SPAN);
	localparam int unsigned LEVEL_SPAN_U = 32'(LEVEL_SPAN);
	localparam int unsigned DIVISOR_U    = 32'(DIVISOR);
	localparam int unsigned OFFSET_U     = 32'(TGT_OFFSET);
	localparam int unsigned ANGLE_MAX_U  = 32'(ANGLE_MAX);
	localparam int unsigned IDLE_SAT_U   = 32'hFFFF;

	typedef struct packed {
		logic [ANGLE_W-1:0]  servo_angle;
		logic [ANGLE_W-1:0]  target_angle;
		logic                servo_enabled;
		logic                moved;
		logic [SAMPLE_W-1:0] light_level;
		logic                is_dark;
	} servo_result_t;

	class servo_scoreboard;
		logic [GAIN_W-1:0]        smoothing_gain;
		logic [GAIN_W-1:0]        slew_gain;
		logic [DEAD_W-1:0]        deadband_degrees;
		logic [IDLE_W-1:0]        idle_limit;
		logic [SAMPLE_W-1:0]      dark_threshold;
		logic [LVL_W-1:0]         level_avg;
		logic [ANG_W-1:0]         angle_now;
		logic [IDLE_W-1:0]        idle_time;
		bit                       drive_on;
		bit                       primed;
		servo_result_t            awaited[$];
		int                       failures;
		int                       results_seen;
		int                       moves_seen;

		function new();
			smoothing_gain   = SMOOTH_RST;
			slew_gain        = SLEW_RST;
			deadband_degrees = DEAD_RST;
			idle_limit       = TIMEOUT_RST;
			dark_threshold   = DARK_RST;
			level_avg        = '0;
			angle_now        = {ANGLE_RST, {FRAC{1'b0}}};
			idle_time        = '0;
			drive_on         = 1'b0;
			primed           = 1'b0;
			failures         = 0;
			results_seen     = 0;
			moves_seen       = 0;
		endfunction

		// Register writes keep only the bits of each register; other indexes do nothing.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_SMOOTHING_GAIN:   smoothing_gain   = value[GAIN_W-1:0];
				CFG_SLEW_GAIN:        slew_gain        = value[GAIN_W-1:0];
				CFG_DEADBAND_DEGREES: deadband_degrees = value[DEAD_W-1:0];
				CFG_IDLE_LIMIT:       idle_limit       = value[IDLE_W-1:0];
				CFG_DARK_THRESHOLD:   dark_threshold   = value[SAMPLE_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned effective_gain(logic [GAIN_W-1:0] g);
			int unsigned v;
			v = 32'(g);
			return (v > ONE_U) ? ONE_U : v;
		endfunction

		function int unsigned angle_for_level(int unsigned lvl);
			int unsigned raw;
			raw = (lvl * LEVEL_SPAN_U) / DIVISOR_U;
			if (raw <= OFFSET_U) begin
				return 0;
			end
			raw = raw - OFFSET_U;
			return (raw > ANGLE_MAX_U) ? ANGLE_MAX_U : raw;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] sample, logic [ELAPSED_W-1:0] elapsed);
			int unsigned   s, e, g, acc, target, tq, mag, band, stride, idle_sum, avg, ang;
			int unsigned   dark_q;
			bit            up;
			bit            stepped;
			servo_result_t r;
			s = 32'(sample);
			e = 32'(elapsed);
			stepped = 1'b0;
			if (!primed) begin
				primed    = 1'b1;
				level_avg = LVL_W'(s << FRAC);
				angle_now = ANG_W'(((s * ANGLE_SPAN_U) / DIVISOR_U) << FRAC);
				target    = angle_for_level(s);
			end else begin
				g   = effective_gain(smoothing_gain);
				avg = 32'(level_avg);
				acc = g * (s << FRAC) + (ONE_U - g) * avg;
				level_avg = LVL_W'(acc >> 8);
				avg = 32'(level_avg);
				target = angle_for_level(avg >> FRAC);
				ang  = 32'(angle_now);
				tq   = target << FRAC;
				up   = (tq >= ang);
				mag  = up ? tq - ang : ang - tq;
				band = 32'(deadband_degrees) << FRAC;
				if (mag > band) begin
					// Even a step that truncates to nothing counts as a move.
					stride    = (mag * effective_gain(slew_gain)) >> 8;
					ang       = up ? ang + stride : ang - stride;
					angle_now = ANG_W'(ang);
					drive_on  = 1'b1;
					idle_time = '0;
					stepped   = 1'b1;
				end else begin
					idle_sum = 32'(idle_time) + e;
					if (idle_sum > IDLE_SAT_U) begin
						idle_sum = IDLE_SAT_U;
					end
					idle_time = IDLE_W'(idle_sum);
					if (drive_on && idle_time > idle_limit) begin
						drive_on = 1'b0;
					end
				end
			end
			avg    = 32'(level_avg);
			ang    = 32'(angle_now);
			dark_q = 32'(dark_threshold) << FRAC;
			r.servo_angle   = ANGLE_W'(ang >> FRAC);
			r.target_angle  = ANGLE_W'(target);
			r.servo_enabled = drive_on;
			r.moved         = stepped;
			r.light_level   = SAMPLE_W'(avg >> FRAC);
			r.is_dark       = (avg < dark_q);
			awaited.push_back(r);
		endfunction

		function void check_result(servo_result_t got);
			servo_result_t want;
			string         bad;
			results_seen++;
			if (got.moved) begin
				moves_seen++;
			end
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTED) begin
					$display("Result %0d arrived with nothing awaited: angle %0d target %0d",
						results_seen, got.servo_angle, got.target_angle);
				end
				return;
			end
			want = awaited.pop_front();
			bad = "";
			if (got.servo_angle !== want.servo_angle)     bad = {bad, " servo_angle"};
			if (got.target_angle !== want.target_angle)   bad = {bad, " target_angle"};
			if (got.servo_enabled !== want.servo_enabled) bad = {bad, " servo_enabled"};
			if (got.moved !== want.moved)                 bad = {bad, " moved"};
			if (got.light_level !== want.light_level)     bad = {bad, " light_level"};
			if (got.is_dark !== want.is_dark)             bad = {bad, " is_dark"};
			if (bad != "") begin
				failures++;
				if (failures <= MAX_REPORTED) begin
					$display("Result %0d differs in%s", results_seen, bad);
					$display("  expected angle %0d target %0d en %0b moved %0b level %0d dark %0b",
						want.servo_angle, want.target_angle, want.servo_enabled, want.moved,
						want.light_level, want.is_dark);
					$display("  actual   angle %0d target %0d en %0b moved %0b level %0d dark %0b",
						got.servo_angle, got.target_angle, got.servo_enabled, got.moved,
						got.light_level, got.is_dark);
				end
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

endpackage

[tb/light_to_servo_smoothing_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light to servo smoothing unit: self-checking testbench
// Feeds light samples through the valid/ready sample channel under a series
// of register settings, predicts every result with a scoreboard model of the
// filter and servo slew, and checks each returned result field by field.
// ----------------------------------------------------------------------------
module light_to_servo_smoothing_unit_test;
	import lss_pkg::*;
	import lss_scoreboard_pkg::*;

	// The longest quiet spell in a correct run is the long receiver hold-off
	// plus one item and a short idle burst. The stall limit is several times
	// that.
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int SAMPLE_MAX    = 1023;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	lss_sample_if sample_ch();
	lss_result_if result_ch();

	servo_scoreboard board;

	bit  idling_on;
	bit  hold_request;
	int  quiet_cycles;
	int  items_sent;
	int  settings_used;
	logic [SAMPLE_W-1:0] plateau;

	// Opening samples under the reset settings: the priming sample at full
	// scale, a dark run that drags the level and the servo down, a bright
	// run back up, then a few quieter steps that let the idle time build.
	logic [SAMPLE_W-1:0]  warm_samples [14] = '{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0,
		10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd512, 10'd512, 10'd512, 10'd512, 10'd1};
	logic [ELAPSED_W-1:0] warm_elapsed [14] = '{8'd255, 8'd255, 8'd0, 8'd128, 8'd1,
		8'd20, 8'd0, 8'd255, 8'd40, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254};

	// With unity gains, no deadband and no timeout, the level follows the
	// sample, the angle lands on its target in one step, and the drive
	// detaches on the first idle item with any elapsed time at all.
	logic [SAMPLE_W-1:0]  edge_samples [10] = '{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023,
		10'd1023, 10'd511, 10'd511, 10'd1, 10'd1022};
	logic [ELAPSED_W-1:0] edge_elapsed [10] = '{8'd0, 8'd0, 8'd1, 8'd255, 8'd0, 8'd7,
		8'd64, 8'd0, 8'd255, 8'd128};

	light_to_servo_smoothing_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side. The ready line idles in short random bursts, and when the
	// stimulus asks for it, holds off for a long stretch counted here, so
	// that the unit finishes an item it cannot hand over and stalls its input.
	initial begin : result_sink
		int gap;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4);
				result_ch.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Every result transfer goes straight to the scoreboard. All inputs are
	// driven with nonblocking assignments, so the values seen here are the
	// ones the unit saw at this edge.
	always @(posedge clk) begin : result_monitor
		servo_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.servo_angle   = result_ch.servo_angle;
			got.target_angle  = result_ch.target_angle;
			got.servo_enabled = result_ch.servo_enabled;
			got.moved         = result_ch.moved;
			got.light_level   = result_ch.light_level;
			got.is_dark       = result_ch.is_dark;
			board.check_result(got);
		end
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("No transfer for %0d cycles, %0d results still awaited",
				quiet_cycles, board.outstanding());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one sample and returns at the edge where it is transferred. The
	// valid line is left high, so back-to-back samples need no extra step;
	// an idle burst, when one is drawn, lowers it first.
	task automatic send_sample(logic [SAMPLE_W-1:0] s, logic [ELAPSED_W-1:0] e);
		int gap;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.light_sample <= s;
		sample_ch.elapsed_ms   <= e;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		board.note_sample(s, e);
		items_sent++;
	endtask

	// One register write, taken at the next edge. The caller lowers the
	// write enable once the whole batch is done.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.write_reg(idx, value);
	endtask

	// Writes all five registers and one unused index. Values are written as
	// given, so any bits above a register's width are left for the unit to drop.
	task automatic program_regs(logic [CFG_W-1:0] smooth, logic [CFG_W-1:0] slew,
		logic [CFG_W-1:0] band, logic [CFG_W-1:0] timeout, logic [CFG_W-1:0] dark);
		write_reg(CFG_SMOOTHING_GAIN, smooth);
		write_reg(CFG_SLEW_GAIN, slew);
		write_reg(CFG_DEADBAND_DEGREES, band);
		write_reg(CFG_IDLE_LIMIT, timeout);
		write_reg(CFG_DARK_THRESHOLD, dark);
		write_reg(CFG_UNUSED_IDX, CFG_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Stops offering samples and waits until every awaited result has been
	// taken, then lets the unit settle back to idle.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random samples shaped like a real sensor: the light sits on a plateau
	// with a little jitter and now and then jumps to a new one, which is what
	// drives the filter towards a fresh target and makes the servo move. A
	// small share of samples are pure noise.
	task automatic run_random(int count, int lo_ms, int hi_ms);
		int                   k;
		int                   pick;
		int                   level;
		logic [SAMPLE_W-1:0]  s;
		logic [ELAPSED_W-1:0] e;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				plateau = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			end
			if (pick == 15) begin
				s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			end else begin
				level = int'(plateau) + int'($urandom_range(0, 16)) - 8;
				if (level < 0) level = 0;
				if (level > SAMPLE_MAX) level = SAMPLE_MAX;
				s = SAMPLE_W'(level);
			end
			e = ELAPSED_W'($urandom_range(lo_ms, hi_ms));
			if ($urandom_range(0, 19) == 0) begin
				e = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			send_sample(s, e);
		end
	endtask

	initial begin : stimulus
		int k;
		board         = new();
		idling_on     = 1'b1;
		hold_request  = 1'b0;
		items_sent    = 0;
		settings_used = 0;
		plateau       = 10'd512;

		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_idx                <= CFG_SMOOTHING_GAIN;
		cfg_data               <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.light_sample <= '0;
		sample_ch.elapsed_ms   <= '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings; the very first sample primes the filter.
		for (k = 0; k < 14; k++) begin
			send_sample(warm_samples[k], warm_elapsed[k]);
		end
		wait_drained();

		// Unity gains, no deadband, no timeout, and a dark threshold at full
		// scale, so every level short of the brightest counts as dark.
		program_regs(CFG_W'(GAIN_ONE), CFG_W'(GAIN_ONE), 16'd0, 16'd0, 16'd1023);
		for (k = 0; k < 10; k++) begin
			send_sample(edge_samples[k], edge_elapsed[k]);
		end
		run_random(110, 0, 255);
		wait_drained();

		// Slowest gains and a deadband of a full sweep: the servo never
		// moves and nothing is dark.
		program_regs(16'd1, 16'd1, 16'd180, 16'd65535, 16'd0);
		run_random(100, 0, 60);
		wait_drained();

		// Zero gains hold the level and angle, and a deadband beyond any gap
		// keeps every item idle; long elapsed times drive the idle count into
		// saturation without passing the largest timeout.
		program_regs(16'd0, 16'd0, 16'd255, 16'd65535, 16'd512);
		run_random(300, 200, 255);
		wait_drained();

		// Gains above one act as one. This phase also carries the pressure
		// tests: a long receiver hold-off while samples keep coming, and a
		// sender pause until every result is home.
		program_regs(16'd511, 16'd300, 16'd8, 16'd500, 16'd300);
		run_random(20, 0, 100);
		hold_request = 1'b1;
		run_random(40, 0, 100);
		wait_drained();
		repeat ($urandom_range(20, 60)) @(posedge clk);
		run_random(40, 0, 100);
		wait_drained();

		// Fully random settings, written with junk in the unused upper bits.
		for (k = 0; k < 3; k++) begin
			program_regs(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
				CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
				CFG_W'($urandom_range(0, 65535)));
			run_random(100, 0, 255);
			wait_drained();
		end

		// Back to the reset values, with both sides at full rate.
		idling_on = 1'b0;
		program_regs(CFG_W'(SMOOTH_RST), CFG_W'(SLEW_RST), CFG_W'(DEAD_RST), TIMEOUT_RST,
			CFG_W'(DARK_RST));
		run_random(100, 0, 80);
		wait_drained();

		$display("Sent %0d samples under %0d register settings, long stall and drain included.",
			items_sent, settings_used);
		$display("Checked %0d results, %0d of them servo moves, %0d failures.",
			board.results_seen, board.moves_seen, board.failures);
		if (board.failures == 0 && board.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
